### rtl/core/pems_pkg.sv
// ----------------------------------------------------------------------------
// pems_pkg
// Shared types, register indexes, reset values and Q16.16 clip helpers for
// the polar Euler motion step block.
// ----------------------------------------------------------------------------
`default_nettype none

package pems_pkg;

	// fixed-point format
	localparam int Q_W    = 32;
	localparam int Q_FRAC = 16;
	localparam int P_W    = 2 * Q_W;
	localparam int H_W    = 31;
	localparam int IDX_W  = 6;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_TANGENTIAL = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_RADIAL     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_RADIUS      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_RADIAL_RATE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_ANG_RATE    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_ANGLE       = 3'd6;

	typedef logic signed [Q_W-1:0] q_t;

	// register reset values
	localparam logic [H_W-1:0] TIME_STEP_RST   = 31'd655;
	localparam q_t             INIT_RADIUS_RST = 32'sd65536;

	localparam q_t Q_MAX = 32'sh7fff_ffff;
	localparam q_t Q_MIN = 32'sh8000_0000;

	typedef struct packed {
		q_t   val;
		logic sat;
	} q_clip_t;

	// multiplier operand pairs
	typedef enum logic [2:0] {
		MS_NONE,
		MS_RP_TP,
		MS_TP_TP,
		MS_H_RP,
		MS_H_TP,
		MS_R_A,
		MS_H_C,
		MS_H_Q
	} mul_sel_t;

	// what the post stage does with the registered product
	typedef enum logic [3:0] {
		PS_NONE,
		PS_NUM,
		PS_A,
		PS_NR,
		PS_NANG,
		PS_C,
		PS_NRP,
		PS_NTP,
		PS_HOLD,
		PS_QSAT
	} post_sel_t;

	// controller to datapath
	typedef struct packed {
		logic      clr;
		logic      load;
		logic      fault;
		logic      div_start;
		logic      commit;
		logic      publish;
		mul_sel_t  mul_sel;
		post_sel_t post_sel;
	} pems_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic r_zero;
		logic div_busy;
	} pems_sts_t;

	// clip a shifted product to Q16.16
	function automatic q_clip_t clip_wide(input logic signed [P_W-1:0] v);
		q_clip_t r;
		logic    hi_ones;
		logic    hi_zeros;
		hi_ones  = &v[P_W-1:Q_W-1];
		hi_zeros = ~|v[P_W-1:Q_W-1];
		r.sat    = ~(hi_ones | hi_zeros);
		if (r.sat) begin
			r.val = v[P_W-1] ? Q_MIN : Q_MAX;
		end else begin
			r.val = v[Q_W-1:0];
		end
		return r;
	endfunction

	// clip a one-bit-grown sum to Q16.16
	function automatic q_clip_t clip_sum(input logic signed [Q_W:0] v);
		q_clip_t r;
		r.sat = v[Q_W] ^ v[Q_W-1];
		if (r.sat) begin
			r.val = v[Q_W] ? Q_MIN : Q_MAX;
		end else begin
			r.val = v[Q_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/core/polar_euler_motion_step.sv
// ----------------------------------------------------------------------------
// polar_euler_motion_step
// Explicit Euler integration of planar motion in polar coordinates, signed
// Q16.16. A restart beat loads radius, radial rate, angular rate and angle
// from the init registers and reports them as step 0; every other beat up
// to step STEPS-1 advances all four from their old values, with saturation
// (the angular rate is held on a zero radius), and reports one result beat.
// The seven products run on one shared 32x32 multiplier alongside the
// 32-iteration radix-2 divider (one quotient bit per cycle), and the last
// product waits for the quotient. Restart beats and beats after the run is
// complete (STEPS-1 steps) skip the arithmetic and go straight to publish.
// One beat is in work at a time; the input stalls until its result has
// entered the output register, which holds while the output is stalled. The
// configuration port is always ready and must only be written while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module polar_euler_motion_step #(
	parameter int STEPS = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [pems_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pems_pkg::Q_W-1:0]          cfg_data,
	// input beats
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              restart,
	// result beats
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [pems_pkg::IDX_W-1:0]        step_index,
	output pems_pkg::q_t                      radius_out,
	output pems_pkg::q_t                      radial_rate_out,
	output pems_pkg::q_t                      ang_rate_out,
	output pems_pkg::q_t                      angle_out,
	output logic                              last,
	output logic                              div_fault,
	output logic                              saturated
);
	import pems_pkg::*;

	pems_cmd_t cmd;
	pems_sts_t sts;

	assign cfg_ready = 1'b1;

	pems_ctrl #(
		.STEPS (STEPS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.restart    (restart),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.step_index (step_index),
		.last       (last),
		.cmd        (cmd),
		.sts        (sts)
	);

	pems_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr          (cfg_valid & cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.cmd             (cmd),
		.sts             (sts),
		.radius_out      (radius_out),
		.radial_rate_out (radial_rate_out),
		.ang_rate_out    (ang_rate_out),
		.angle_out       (angle_out),
		.div_fault       (div_fault),
		.saturated       (saturated)
	);

`ifndef SYNTH
	// one beat in work at a time
	a_single_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input accepted while a beat is in work");

	// divider only started on a nonzero radius and when free
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> (!sts.r_zero && !sts.div_busy))
		else $error("divider started on zero radius or while busy");

	// state never updated under a running division
	a_commit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !sts.div_busy)
		else $error("state committed while divider busy");

	// last flag matches the reported index
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last) |-> (step_index == IDX_W'((STEPS - 1) % (2 ** IDX_W))))
		else $error("last set on a wrong step index");
`endif

endmodule

`default_nettype wire

### rtl/core/pems_div.sv
// ----------------------------------------------------------------------------
// pems_div
// Radix-2 restoring divider for (num * 2^16) / den, rounded toward zero and
// clipped to Q16.16. One quotient bit per cycle, then the sign and clip are registered.
// ----------------------------------------------------------------------------
`default_nettype none

module pems_div (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  pems_pkg::q_t  num,
	input  pems_pkg::q_t  den,
	output logic          busy,
	output pems_pkg::q_t  quo,
	output logic          sat
);
	import pems_pkg::*;

	localparam int CNT_W = $clog2(Q_W);

	logic             run_q;
	logic             fin_q;
	logic [CNT_W-1:0] cnt_q;
	logic [Q_W-1:0]   rem_q;
	logic [Q_W-1:0]   sh_q;
	logic [Q_W-1:0]   dmag_q;
	logic             neg_q;
	logic             ovf_q;
	q_t               quo_q;
	logic             sat_q;

	logic [Q_W-1:0]   nmag;
	logic [Q_W-1:0]   dmag;
	logic [Q_W+1:0]   diff;
	logic             ge;
	q_t               fin_val;
	logic             fin_sat;

	// operand magnitudes
	assign nmag = num[Q_W-1] ? Q_W'(-num) : num;
	assign dmag = den[Q_W-1] ? Q_W'(-den) : den;

	// trial subtract of the shifted remainder
	assign diff = {1'b0, rem_q, sh_q[Q_W-1]} - {2'b00, dmag_q};
	assign ge   = ~diff[Q_W+1];

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			fin_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (start) begin
				run_q <= 1'b1;
				fin_q <= 1'b0;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(Q_W - 1)) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end else begin
				fin_q <= 1'b0;
			end
		end
	end

	// remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= {Q_FRAC'(0), nmag[Q_W-1:Q_FRAC]};
			sh_q   <= {nmag[Q_FRAC-1:0], {Q_FRAC{1'b0}}};
			dmag_q <= dmag;
			neg_q  <= num[Q_W-1] ^ den[Q_W-1];
			ovf_q  <= {Q_FRAC'(0), nmag[Q_W-1:Q_FRAC]} >= dmag;
		end else if (run_q) begin
			rem_q <= ge ? diff[Q_W-1:0] : {rem_q[Q_W-2:0], sh_q[Q_W-1]};
			sh_q  <= {sh_q[Q_W-2:0], ge};
		end
	end

	// sign and clip of the magnitude quotient
	always_comb begin
		fin_val = sh_q;
		fin_sat = 1'b0;
		if (ovf_q) begin
			fin_sat = 1'b1;
			fin_val = neg_q ? Q_MIN : Q_MAX;
		end else if (neg_q) begin
			if (sh_q[Q_W-1] && (|sh_q[Q_W-2:0])) begin
				fin_sat = 1'b1;
				fin_val = Q_MIN;
			end else begin
				fin_val = q_t'(Q_W'(-sh_q));
			end
		end else if (sh_q[Q_W-1]) begin
			fin_sat = 1'b1;
			fin_val = Q_MAX;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_q) begin
			quo_q <= fin_val;
			sat_q <= fin_sat;
		end
	end

	assign busy = run_q | fin_q;
	assign quo  = quo_q;
	assign sat  = sat_q;

endmodule

`default_nettype wire

### rtl/core/pems_dp.sv
// ----------------------------------------------------------------------------
// pems_dp
// Datapath: configuration registers, motion state, one shared 32x32
// multiplier with a shift/clip/add post stage, the divider and the result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module pems_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr,
	input  logic [pems_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pems_pkg::Q_W-1:0]           cfg_data,
	input  pems_pkg::pems_cmd_t                cmd,
	output pems_pkg::pems_sts_t                sts,
	output pems_pkg::q_t                       radius_out,
	output pems_pkg::q_t                       radial_rate_out,
	output pems_pkg::q_t                       ang_rate_out,
	output pems_pkg::q_t                       angle_out,
	output logic                               div_fault,
	output logic                               saturated
);
	import pems_pkg::*;

	// configuration
	logic [H_W-1:0] h_q;
	q_t             at_q;
	q_t             ar_q;
	q_t             ir_q;
	q_t             irp_q;
	q_t             itp_q;
	q_t             iang_q;

	// motion state
	q_t r_q;
	q_t rp_q;
	q_t tp_q;
	q_t ang_q;

	// intermediates and next state
	q_t num_q;
	q_t a_q;
	q_t c_q;
	q_t nr_q;
	q_t nrp_q;
	q_t ntp_q;
	q_t nang_q;

	logic fault_q;
	logic sat_q;

	// result register
	q_t   r_out_q;
	q_t   rp_out_q;
	q_t   tp_out_q;
	q_t   ang_out_q;
	logic fault_out_q;
	logic sat_out_q;

	// multiplier
	q_t                    h_ext;
	q_t                    mul_a;
	q_t                    mul_b;
	logic signed [P_W-1:0] mul_p;
	logic signed [P_W-1:0] prod_q;

	// post stage
	logic signed [P_W-1:0] shifted;
	q_clip_t               tc;
	q_t                    base;
	logic signed [Q_W:0]   sum;
	q_clip_t               sc;
	logic                  post_sat;

	// divider
	q_t   div_quo;
	logic div_sat;
	logic div_busy;

	assign h_ext = q_t'({1'b0, h_q});

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q    <= TIME_STEP_RST;
			at_q   <= '0;
			ar_q   <= '0;
			ir_q   <= INIT_RADIUS_RST;
			irp_q  <= '0;
			itp_q  <= '0;
			iang_q <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				REG_TIME_STEP:        h_q    <= cfg_data[H_W-1:0];
				REG_ACCEL_TANGENTIAL: at_q   <= cfg_data;
				REG_ACCEL_RADIAL:     ar_q   <= cfg_data;
				REG_INIT_RADIUS:      ir_q   <= cfg_data;
				REG_INIT_RADIAL_RATE: irp_q  <= cfg_data;
				REG_INIT_ANG_RATE:    itp_q  <= cfg_data;
				REG_INIT_ANGLE:       iang_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.mul_sel)
			MS_NONE: begin
				mul_a = '0;
				mul_b = '0;
			end
			MS_RP_TP: begin
				mul_a = rp_q;
				mul_b = tp_q;
			end
			MS_TP_TP: begin
				mul_a = tp_q;
				mul_b = tp_q;
			end
			MS_H_RP: begin
				mul_a = h_ext;
				mul_b = rp_q;
			end
			MS_H_TP: begin
				mul_a = h_ext;
				mul_b = tp_q;
			end
			MS_R_A: begin
				mul_a = r_q;
				mul_b = a_q;
			end
			MS_H_C: begin
				mul_a = h_ext;
				mul_b = c_q;
			end
			MS_H_Q: begin
				mul_a = h_ext;
				mul_b = div_quo;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	always_ff @(posedge clk) begin
		prod_q <= mul_p;
	end

	// floor shift, clip, then add to the base operand (the numerator term is
	// subtracted) and clip again; it has the factor 2, so it shifts one bit less
	assign shifted = (cmd.post_sel == PS_NUM) ? (prod_q >>> (Q_FRAC - 1))
	                                          : (prod_q >>> Q_FRAC);
	assign tc = clip_wide(shifted);

	always_comb begin
		base = '0;
		unique case (cmd.post_sel)
			PS_NUM:  base = at_q;
			PS_NR:   base = r_q;
			PS_NANG: base = ang_q;
			PS_C:    base = ar_q;
			PS_NRP:  base = rp_q;
			PS_NTP:  base = tp_q;
			default: base = '0;
		endcase
	end

	assign sum = (cmd.post_sel == PS_NUM) ? ({base[Q_W-1], base} - {tc.val[Q_W-1], tc.val})
	                                      : ({base[Q_W-1], base} + {tc.val[Q_W-1], tc.val});
	assign sc  = clip_sum(sum);

	always_comb begin
		post_sat = 1'b0;
		unique case (cmd.post_sel)
			PS_A:    post_sat = tc.sat;
			PS_NUM, PS_NR, PS_NANG, PS_C, PS_NRP, PS_NTP:
			         post_sat = tc.sat | sc.sat;
			PS_QSAT: post_sat = div_sat;
			default: post_sat = 1'b0;
		endcase
	end

	// intermediate and next-state registers
	always_ff @(posedge clk) begin
		unique case (cmd.post_sel)
			PS_NUM:  num_q  <= sc.val;
			PS_A:    a_q    <= tc.val;
			PS_NR:   nr_q   <= sc.val;
			PS_NANG: nang_q <= sc.val;
			PS_C:    c_q    <= sc.val;
			PS_NRP:  nrp_q  <= sc.val;
			PS_NTP:  ntp_q  <= sc.val;
			PS_HOLD: ntp_q  <= tp_q;
			default: ;
		endcase
	end

	// motion state and step flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q     <= '0;
			rp_q    <= '0;
			tp_q    <= '0;
			ang_q   <= '0;
			fault_q <= 1'b0;
			sat_q   <= 1'b0;
		end else begin
			if (cmd.load) begin
				r_q   <= ir_q;
				rp_q  <= irp_q;
				tp_q  <= itp_q;
				ang_q <= iang_q;
			end else if (cmd.commit) begin
				r_q   <= nr_q;
				rp_q  <= nrp_q;
				tp_q  <= ntp_q;
				ang_q <= nang_q;
			end
			if (cmd.clr) begin
				fault_q <= 1'b0;
				sat_q   <= 1'b0;
			end else begin
				fault_q <= fault_q | cmd.fault;
				sat_q   <= sat_q | post_sat;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			r_out_q     <= r_q;
			rp_out_q    <= rp_q;
			tp_out_q    <= tp_q;
			ang_out_q   <= ang_q;
			fault_out_q <= fault_q;
			sat_out_q   <= sat_q;
		end
	end

	pems_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (num_q),
		.den    (r_q),
		.busy   (div_busy),
		.quo    (div_quo),
		.sat    (div_sat)
	);

	assign sts.r_zero   = (r_q == '0);
	assign sts.div_busy = div_busy;

	assign radius_out      = r_out_q;
	assign radial_rate_out = rp_out_q;
	assign ang_rate_out    = tp_out_q;
	assign angle_out       = ang_out_q;
	assign div_fault       = fault_out_q;
	assign saturated       = sat_out_q;

endmodule

`default_nettype wire

### rtl/core/pems_ctrl.sv
// ----------------------------------------------------------------------------
// pems_ctrl
// Controller: input and output handshakes, step counter and the schedule of
// multiplier, post-stage and divider commands for one Euler step.
// ----------------------------------------------------------------------------
`default_nettype none

module pems_ctrl #(
	parameter int STEPS = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        restart,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [pems_pkg::IDX_W-1:0]  step_index,
	output logic                        last,
	output pems_pkg::pems_cmd_t         cmd,
	input  pems_pkg::pems_sts_t         sts
);
	import pems_pkg::*;

	localparam int CNT_W = ($clog2(STEPS) > IDX_W) ? $clog2(STEPS) : IDX_W;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_MUL0   = 4'd1;
	localparam logic [3:0] S_MUL1   = 4'd2;
	localparam logic [3:0] S_MUL2   = 4'd3;
	localparam logic [3:0] S_MUL3   = 4'd4;
	localparam logic [3:0] S_MUL4   = 4'd5;
	localparam logic [3:0] S_MUL5   = 4'd6;
	localparam logic [3:0] S_MUL6   = 4'd7;
	localparam logic [3:0] S_MUL7   = 4'd8;
	localparam logic [3:0] S_DWAIT  = 4'd9;
	localparam logic [3:0] S_MUL9   = 4'd10;
	localparam logic [3:0] S_COMMIT = 4'd11;
	localparam logic [3:0] S_PUB    = 4'd12;

	logic [3:0]       state_q;
	logic [3:0]       state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic [IDX_W-1:0] idx_q;
	logic             last_q;

	logic accept;
	logic full;
	logic pub_ok;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid & ~in_stall;
	assign full     = (cnt_q == CNT_W'(STEPS - 1));
	assign pub_ok   = ~out_valid_q | ~out_stall;

	// step schedule
	always_comb begin
		cmd          = '0;
		cmd.mul_sel  = MS_NONE;
		cmd.post_sel = PS_NONE;
		state_d      = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.clr = 1'b1;
					if (restart) begin
						cmd.load = 1'b1;
						state_d  = S_PUB;
					end else if (full) begin
						state_d = S_PUB;
					end else begin
						state_d = S_MUL0;
					end
				end
			end
			S_MUL0: begin
				cmd.mul_sel = MS_RP_TP;
				state_d     = S_MUL1;
			end
			S_MUL1: begin
				cmd.mul_sel  = MS_TP_TP;
				cmd.post_sel = sts.r_zero ? PS_NONE : PS_NUM;
				state_d      = S_MUL2;
			end
			S_MUL2: begin
				cmd.mul_sel   = MS_H_RP;
				cmd.post_sel  = PS_A;
				cmd.div_start = ~sts.r_zero;
				cmd.fault     = sts.r_zero;
				state_d       = S_MUL3;
			end
			S_MUL3: begin
				cmd.mul_sel  = MS_H_TP;
				cmd.post_sel = PS_NR;
				state_d      = S_MUL4;
			end
			S_MUL4: begin
				cmd.mul_sel  = MS_R_A;
				cmd.post_sel = PS_NANG;
				state_d      = S_MUL5;
			end
			S_MUL5: begin
				cmd.post_sel = PS_C;
				state_d      = S_MUL6;
			end
			S_MUL6: begin
				cmd.mul_sel = MS_H_C;
				state_d     = S_MUL7;
			end
			S_MUL7: begin
				cmd.post_sel = PS_NRP;
				state_d      = S_DWAIT;
			end
			S_DWAIT: begin
				if (!sts.div_busy) begin
					cmd.mul_sel  = MS_H_Q;
					cmd.post_sel = sts.r_zero ? PS_NONE : PS_QSAT;
					state_d      = S_MUL9;
				end
			end
			S_MUL9: begin
				cmd.post_sel = sts.r_zero ? PS_HOLD : PS_NTP;
				state_d      = S_COMMIT;
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = S_PUB;
			end
			S_PUB: begin
				if (pub_ok) begin
					cmd.publish = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state, step counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && restart) begin
				cnt_q <= '0;
			end else if (cmd.commit) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// index and last flag of the published beat
	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			idx_q  <= cnt_q[IDX_W-1:0];
			last_q <= full;
		end
	end

	assign out_valid  = out_valid_q;
	assign step_index = idx_q;
	assign last       = last_q;

endmodule

`default_nettype wire

### tb/pems_motion_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pems_motion_checker
// Watches the configuration, step and result channels of the polar Euler
// motion step block. Keeps its own copy of the registers and of the motion
// state, works out the result of every accepted step beat in Q16.16 with
// saturation, and compares each accepted result beat field by field with
// the oldest outstanding prediction.
// ----------------------------------------------------------------------------

module pems_motion_checker #(
	parameter int STEPS = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	input  logic                              cfg_ready,
	input  logic [pems_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pems_pkg::Q_W-1:0]          cfg_data,
	input  logic                              in_valid,
	input  logic                              in_stall,
	input  logic                              restart,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  logic [pems_pkg::IDX_W-1:0]        step_index,
	input  pems_pkg::q_t                      radius_out,
	input  pems_pkg::q_t                      radial_rate_out,
	input  pems_pkg::q_t                      ang_rate_out,
	input  pems_pkg::q_t                      angle_out,
	input  logic                              last,
	input  logic                              div_fault,
	input  logic                              saturated,
	output int                                fail_count,
	output int                                beats_pending
);

	import pems_pkg::*;

	localparam longint Q_HI = longint'(Q_MAX);
	localparam longint Q_LO = longint'(Q_MIN);

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		q_t               radius;
		q_t               radial_rate;
		q_t               ang_rate;
		q_t               angle;
		logic             last;
		logic             fault;
		logic             sat;
	} motion_beat_t;

	// register copies
	logic [H_W-1:0] h_reg;
	q_t             at_reg;
	q_t             ar_reg;
	q_t             r0_reg;
	q_t             rp0_reg;
	q_t             tp0_reg;
	q_t             a0_reg;

	// motion state
	q_t             r_st;
	q_t             rp_st;
	q_t             tp_st;
	q_t             a_st;
	int             step_cnt;
	bit             clip_seen;

	motion_beat_t   motion_q[$];
	motion_beat_t   want;

	initial begin
		fail_count    = 0;
		beats_pending = 0;
	end

	// clip to the Q16.16 range and remember that it happened
	function automatic longint clamp_q(input longint v);
		if (v > Q_HI) begin
			clip_seen = 1'b1;
			return Q_HI;
		end
		if (v < Q_LO) begin
			clip_seen = 1'b1;
			return Q_LO;
		end
		return v;
	endfunction

	// product rounded toward minus infinity, then clipped
	function automatic longint qprod(input longint a, input longint b, input int k);
		return clamp_q((a * b) >>> k);
	endfunction

	// one Euler step (or restart) on the local state
	function automatic motion_beat_t advance_motion(input logic rs);
		motion_beat_t res;
		longint       h;
		longint       r;
		longint       rp;
		longint       tp;
		longint       a;
		longint       t;
		longint       nt;
		bit           fault;
		fault     = 1'b0;
		clip_seen = 1'b0;
		if (rs) begin
			r_st     = r0_reg;
			rp_st    = rp0_reg;
			tp_st    = tp0_reg;
			a_st     = a0_reg;
			step_cnt = 0;
		end else if (step_cnt < STEPS - 1) begin
			h  = longint'(h_reg);
			r  = longint'(r_st);
			rp = longint'(rp_st);
			tp = longint'(tp_st);
			a  = longint'(a_st);
			// angular rate: (at - 2 rp tp) / r, held on zero radius
			if (r == 0) begin
				fault = 1'b1;
				nt    = tp;
			end else begin
				t  = qprod(rp, tp, Q_FRAC - 1);
				t  = clamp_q(longint'(at_reg) - t);
				t  = clamp_q((t <<< Q_FRAC) / r);
				t  = qprod(h, t, Q_FRAC);
				nt = clamp_q(tp + t);
			end
			// radial rate: ar + r tp^2
			t     = qprod(tp, tp, Q_FRAC);
			t     = qprod(r, t, Q_FRAC);
			t     = clamp_q(longint'(ar_reg) + t);
			t     = qprod(h, t, Q_FRAC);
			rp_st = q_t'(clamp_q(rp + t));
			// radius and angle from the old rates
			t     = qprod(h, rp, Q_FRAC);
			r_st  = q_t'(clamp_q(r + t));
			t     = qprod(h, tp, Q_FRAC);
			a_st  = q_t'(clamp_q(a + t));
			tp_st = q_t'(nt);
			step_cnt++;
		end
		res.idx         = step_cnt[IDX_W-1:0];
		res.radius      = r_st;
		res.radial_rate = rp_st;
		res.ang_rate    = tp_st;
		res.angle       = a_st;
		res.last        = (step_cnt == STEPS - 1);
		res.fault       = fault;
		res.sat         = rs ? 1'b0 : clip_seen;
		return res;
	endfunction

	task automatic check_field(input string fld, input logic [31:0] exp_v,
			input logic [31:0] got_v);
		if (got_v !== exp_v) begin
			$error("%s: expected %h, got %h", fld, exp_v, got_v);
			fail_count++;
		end
	endtask

	// register writes, step beats, result beats
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_reg    = TIME_STEP_RST;
			at_reg   = '0;
			ar_reg   = '0;
			r0_reg   = INIT_RADIUS_RST;
			rp0_reg  = '0;
			tp0_reg  = '0;
			a0_reg   = '0;
			r_st     = '0;
			rp_st    = '0;
			tp_st    = '0;
			a_st     = '0;
			step_cnt = 0;
			motion_q.delete();
			beats_pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_TIME_STEP:        h_reg   = cfg_data[H_W-1:0];
					REG_ACCEL_TANGENTIAL: at_reg  = cfg_data;
					REG_ACCEL_RADIAL:     ar_reg  = cfg_data;
					REG_INIT_RADIUS:      r0_reg  = cfg_data;
					REG_INIT_RADIAL_RATE: rp0_reg = cfg_data;
					REG_INIT_ANG_RATE:    tp0_reg = cfg_data;
					REG_INIT_ANGLE:       a0_reg  = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				motion_q.push_back(advance_motion(restart));
			end
			if (out_valid && !out_stall) begin
				if (motion_q.size() == 0) begin
					$error("result beat with no step beat outstanding");
					fail_count++;
				end else begin
					want = motion_q.pop_front();
					check_field("step_index", want.idx, step_index);
					check_field("radius_out", want.radius, radius_out);
					check_field("radial_rate_out", want.radial_rate, radial_rate_out);
					check_field("ang_rate_out", want.ang_rate, ang_rate_out);
					check_field("angle_out", want.angle, angle_out);
					check_field("last", want.last, last);
					check_field("div_fault", want.fault, div_fault);
					check_field("saturated", want.sat, saturated);
				end
			end
			beats_pending = motion_q.size();
		end
	end

endmodule

### tb/tb_polar_euler_motion_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_polar_euler_motion_step
// Drives restart and step beats into the polar Euler motion step block under
// several register settings and idle patterns, with a long output hold-off
// and drained pauses, while a checker predicts and compares every result.
// ----------------------------------------------------------------------------

module tb_polar_euler_motion_step;

	import pems_pkg::*;

	localparam int STEPS        = 64;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int DRAIN_CYCLES = 64;
	localparam int SEG_BEATS    = 56;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [Q_W-1:0]       cfg_data  = '0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	logic                 restart   = 1'b0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [IDX_W-1:0]     step_index;
	q_t                   radius_out;
	q_t                   radial_rate_out;
	q_t                   ang_rate_out;
	q_t                   angle_out;
	logic                 last;
	logic                 div_fault;
	logic                 saturated;

	int cycle_cnt  = 0;
	int hold_until = 0;
	int idle_pct   = 0;
	int stall_pct  = 0;
	int beats_sent = 0;
	int fail_count;
	int beats_pending;

	polar_euler_motion_step #(.STEPS(STEPS)) dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.restart         (restart),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.step_index      (step_index),
		.radius_out      (radius_out),
		.radial_rate_out (radial_rate_out),
		.ang_rate_out    (ang_rate_out),
		.angle_out       (angle_out),
		.last            (last),
		.div_fault       (div_fault),
		.saturated       (saturated)
	);

	pems_motion_checker #(.STEPS(STEPS)) u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.restart         (restart),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.step_index      (step_index),
		.radius_out      (radius_out),
		.radial_rate_out (radial_rate_out),
		.ang_rate_out    (ang_rate_out),
		.angle_out       (angle_out),
		.last            (last),
		.div_fault       (div_fault),
		.saturated       (saturated),
		.fail_count      (fail_count),
		.beats_pending   (beats_pending)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// cycle count and timeout
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// result side: long hold-off window or random stall
	always @(negedge clk) begin
		out_stall <= (cycle_cnt < hold_until) || ($urandom_range(99) < stall_pct);
	end

	// one step or restart beat, with random idle cycles ahead of it
	task automatic send_step(input logic rs);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		restart  <= rs;
		do @(posedge clk); while (in_stall);
		beats_sent++;
		@(negedge clk);
	endtask

	// stop sending and wait until every result beat is out
	task automatic drain_steps();
		in_valid <= 1'b0;
		while (beats_pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic load_motion_cfg(input logic [31:0] h, input logic [31:0] at,
			input logic [31:0] ar, input logic [31:0] r0, input logic [31:0] rp0,
			input logic [31:0] tp0, input logic [31:0] a0);
		drain_steps();
		write_reg(REG_TIME_STEP, h);
		write_reg(REG_ACCEL_TANGENTIAL, at);
		write_reg(REG_ACCEL_RADIAL, ar);
		write_reg(REG_INIT_RADIUS, r0);
		write_reg(REG_INIT_RADIAL_RATE, rp0);
		write_reg(REG_INIT_ANG_RATE, tp0);
		write_reg(REG_INIT_ANGLE, a0);
		cfg_valid <= 1'b0;
	endtask

	// mostly within +/- span, sometimes full scale or raw bits
	function automatic logic [31:0] pick_q(input int unsigned span);
		logic [31:0] v;
		case ($urandom_range(9))
			0: begin
				case ($urandom_range(4))
					0:       v = Q_MAX;
					1:       v = Q_MIN;
					2:       v = '0;
					3:       v = 32'd1;
					default: v = '1;
				endcase
			end
			1:       v = $urandom();
			default: v = $urandom_range(2 * span) - span;
		endcase
		return v;
	endfunction

	task automatic random_motion_cfg();
		logic [31:0] h;
		case ($urandom_range(9))
			0: begin
				case ($urandom_range(2))
					0:       h = '0;
					1:       h = 32'd1;
					default: h = 32'h7fff_ffff;
				endcase
			end
			1:       h = $urandom();
			default: h = $urandom_range(6554, 1);
		endcase
		load_motion_cfg(h, pick_q(4 << Q_FRAC), pick_q(4 << Q_FRAC), pick_q(8 << Q_FRAC),
			pick_q(2 << Q_FRAC), pick_q(2 << Q_FRAC), pick_q(32'h7fff_ffff));
	endtask

	initial begin
		int mode;
		int seg;
		int run_len;
		int target;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// step from the all-zero reset state, then restart on reset registers
		send_step(1'b0);
		send_step(1'b1);
		send_step(1'b0);
		send_step(1'b0);

		// largest step, full-scale accelerations and rates, tiny radius
		load_motion_cfg(32'hffff_ffff, Q_MAX, Q_MIN, 32'd1, Q_MAX, Q_MIN, Q_MAX);
		send_step(1'b1);
		repeat (3) send_step(1'b0);

		// zero radius holds the angular rate
		load_motion_cfg(32'd655, 32'sd65536, '0, '0, 32'sd65536, 32'sd131072, '0);
		send_step(1'b1);
		repeat (2) send_step(1'b0);

		// full-scale negative radius, smallest step
		load_motion_cfg(32'd1, Q_MIN, Q_MAX, Q_MIN, '1, 32'd1, Q_MIN);
		send_step(1'b1);
		repeat (2) send_step(1'b0);

		// unknown register index changes nothing
		drain_steps();
		write_reg(REG_UNUSED, '1);
		cfg_valid <= 1'b0;
		send_step(1'b1);
		send_step(1'b0);

		// random runs under each idle pattern
		for (mode = 0; mode < 4; mode++) begin
			case (mode)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 47; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 47; end
				default: begin idle_pct = 21; stall_pct = 21; end
			endcase
			for (seg = 0; seg < 4; seg++) begin
				random_motion_cfg();
				// result side holds off while beats keep coming
				if (seg == 1) begin
					hold_until = cycle_cnt + 400;
				end
				target = beats_sent + SEG_BEATS;
				while (beats_sent < target) begin
					if ($urandom_range(9) != 0) begin
						send_step(1'b1);
						run_len = ($urandom_range(3) == 0) ? $urandom_range(75, 60)
							: $urandom_range(30, 1);
						repeat (run_len) send_step(1'b0);
					end else begin
						send_step(1'($urandom_range(1)));
					end
				end
			end
		end

		in_valid <= 1'b0;
		while (beats_pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

### filelist.f
rtl/core/pems_pkg.sv
rtl/core/pems_div.sv
rtl/core/pems_dp.sv
rtl/core/pems_ctrl.sv
rtl/core/polar_euler_motion_step.sv
tb/pems_motion_checker.sv
tb/tb_polar_euler_motion_step.sv
